[design/hbps2_pkg.sv]
// ============================================================================
// hbps2_pkg
// Shared types, constants and usage-to-scancode lookup for the boot report
// to PS/2 set-1 event translator.
// ============================================================================
package hbps2_pkg;

  // Usage codes with special handling
  localparam logic [7:0] USAGE_MIN   = 8'h04;
  localparam logic [7:0] USAGE_CAPS  = 8'h39;
  localparam logic [7:0] USAGE_LIMIT = 8'hE0;
  localparam int         MAP_SIZE    = 102;

  // Repeat delay after reset
  localparam logic [7:0] REPEAT_DELAY_RST = 8'd12;

  // Modifier order: LCtrl, LShift, LAlt, RCtrl, RShift, RAlt
  localparam int MOD_NUM = 6;
  localparam int MOD_POS [MOD_NUM] = '{0, 1, 2, 4, 5, 6};
  localparam logic [7:0] MOD_CODES [MOD_NUM] =
    '{8'h1D, 8'h2A, 8'h38, 8'h1D, 8'h36, 8'h38};
  localparam logic [MOD_NUM-1:0] MOD_EXT = 6'b101000;

  // Set-1 scancode per usage, zero where unmapped
  localparam logic [7:0] USAGE_MAP [MAP_SIZE] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25,
    8'h26, 8'h32,
    8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F, 8'h11, 8'h2D,
    8'h15, 8'h2C,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B,
    8'h27, 8'h28,
    8'h29, 8'h33, 8'h34, 8'h35,
    8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h57,
    8'h58,
    8'h00, 8'h46, 8'h00,
    8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51,
    8'h4D, 8'h4B, 8'h50, 8'h48,
    8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E, 8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C,
    8'h4D, 8'h47,
    8'h48, 8'h49, 8'h52, 8'h53,
    8'h56, 8'h00
  };

  // One event as it leaves the block
  typedef struct packed {
    logic [7:0] scancode;
    logic       extended;
    logic       released;
    logic       repeated;
    logic       caps;
  } event_t;

  // What one slot lane finds
  typedef struct packed {
    logic       fire;      // usage left/entered the report
    logic [7:0] scancode;
    logic       extended;
  } lane_t;

  function automatic logic [7:0] usage_lookup(input logic [7:0] usage);
    logic [7:0] sc;
    sc = 8'h00;
    if (usage < 8'(MAP_SIZE)) sc = USAGE_MAP[usage[6:0]];
    return sc;
  endfunction

  function automatic logic usage_is_ext(input logic [7:0] usage);
    return (usage >= 8'h49 && usage <= 8'h52) || usage == 8'h54 || usage == 8'h58;
  endfunction

endpackage

[design/hid_boot_report_to_ps2_events_core.sv]
// ============================================================================
// hid_boot_report_to_ps2_events_core
// Boot keyboard report to PS/2 set-1 make/break events with caps toggle and
// typematic repeat.
// ============================================================================
// Throughput: one event per cycle while out_tready is high; the next report
//   enters the pending bank as the last event of the current one moves to
//   the output register (up to 2*KEY_SLOTS+6 events per report).
// Reset: synchronous, active low; clears all key state, repeat_delay to 12.
module hid_boot_report_to_ps2_events_core
  import hbps2_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // modifiers[7:0], key_0..key_5[55:8], valid_keys[58:56], zero fill
  input  logic [63:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scancode[7:0], caps_state[8], zero fill
  output logic [15:0] out_tdata,
  // extended[0], released[1], repeated[2]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  localparam int IN_KEYS  = 6;
  localparam int REL_BASE = MOD_NUM;
  localparam int PRS_BASE = MOD_NUM + KEY_SLOTS;
  localparam int REP_IDX  = MOD_NUM + 2 * KEY_SLOTS;
  localparam int NEV      = REP_IDX + 1;

  // State
  logic [7:0] rep_delay_r;
  logic [7:0] prev_mods_r, prev_mods_nxt;
  logic [7:0] prev_keys_r [KEY_SLOTS];
  logic [7:0] rep_usage_r, rep_usage_nxt;
  logic [7:0] rep_count_r, rep_count_nxt;
  logic       caps_r, caps_nxt;

  logic       accept;
  logic       load_ok;
  logic [7:0] mods;
  logic [2:0] valid_keys;
  logic [7:0] keys [KEY_SLOTS];
  logic       changed;
  lane_t      rel_lane [KEY_SLOTS];
  lane_t      prs_lane [KEY_SLOTS];
  logic [NEV-1:0] ev_valid;
  event_t     ev [NEV];
  logic [7:0] rep_sc;
  event_t     out_ev;
  logic       out_last;

  assign mods       = in_tdata[7:0];
  assign valid_keys = in_tdata[58:56];
  assign accept     = in_tvalid && in_tready;
  assign in_tready  = load_ok;

  // Slots past the valid count, or past the input's six, read as zero
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_keys
    if (i < IN_KEYS) begin : g_live
      assign keys[i] = ({1'b0, valid_keys} > 4'(i)) ? in_tdata[8*i+15 -: 8] : 8'h00;
    end else begin : g_zero
      assign keys[i] = 8'h00;
    end
  end

  always_comb begin
    changed = (mods != prev_mods_r);
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys[i] != prev_keys_r[i]) changed = 1'b1;
    end
  end

  // Release lanes look at old slots, press lanes at new ones
  for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_lanes
    hbps2_lane #(.KEY_SLOTS(KEY_SLOTS)) u_rel (
      .usage  (prev_keys_r[i]),
      .others (keys),
      .lane   (rel_lane[i])
    );
    hbps2_lane #(.KEY_SLOTS(KEY_SLOTS)) u_prs (
      .usage  (keys[i]),
      .others (prev_keys_r),
      .lane   (prs_lane[i])
    );
  end

  assign rep_sc = usage_lookup(rep_usage_r);

  // Event list and next state for this report
  always_comb begin
    logic caps_acc;
    logic rep_cleared;
    ev_valid      = '0;
    caps_acc      = caps_r;
    rep_cleared   = 1'b0;
    rep_usage_nxt = rep_usage_r;
    rep_count_nxt = rep_count_r;
    for (int i = 0; i < NEV; i++) ev[i] = '0;

    // Modifier changes
    for (int i = 0; i < MOD_NUM; i++) begin
      ev_valid[i] = changed && (mods[MOD_POS[i]] != prev_mods_r[MOD_POS[i]]);
      ev[i]       = '{MOD_CODES[i], MOD_EXT[i], ~mods[MOD_POS[i]], 1'b0, caps_r};
    end

    // Breaks
    for (int i = 0; i < KEY_SLOTS; i++) begin
      ev_valid[REL_BASE+i] = changed && rel_lane[i].fire && (rel_lane[i].scancode != 8'h00);
      ev[REL_BASE+i] = '{rel_lane[i].scancode, rel_lane[i].extended, 1'b1, 1'b0, caps_r};
      if (rel_lane[i].fire && prev_keys_r[i] == rep_usage_r) rep_cleared = 1'b1;
    end
    if (rep_cleared) rep_usage_nxt = 8'h00;

    // Makes; caps toggles ahead of its own event
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (prs_lane[i].fire && keys[i] == USAGE_CAPS) caps_acc = ~caps_acc;
      ev_valid[PRS_BASE+i] = changed && prs_lane[i].fire && (prs_lane[i].scancode != 8'h00);
      ev[PRS_BASE+i] = '{prs_lane[i].scancode, prs_lane[i].extended, 1'b0, 1'b0, caps_acc};
      if (prs_lane[i].fire && keys[i] < USAGE_LIMIT && keys[i] != USAGE_CAPS) begin
        rep_usage_nxt = keys[i];
        rep_count_nxt = rep_delay_r;
      end
    end
    caps_nxt = caps_acc;

    // Typematic repeat on an unchanged report
    ev[REP_IDX] = '{rep_sc, usage_is_ext(rep_usage_r), 1'b0, 1'b1, caps_r};
    if (!changed) begin
      rep_usage_nxt = rep_usage_r;
      rep_count_nxt = rep_count_r;
      caps_nxt      = caps_r;
      if (rep_usage_r != 8'h00) begin
        if (rep_count_r != 8'h00) begin
          rep_count_nxt = rep_count_r - 8'd1;
        end else begin
          ev_valid[REP_IDX] = (rep_sc != 8'h00);
        end
      end
    end

    prev_mods_nxt = changed ? mods : prev_mods_r;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_delay_r <= REPEAT_DELAY_RST;
      prev_mods_r <= 8'h00;
      rep_usage_r <= 8'h00;
      rep_count_r <= 8'h00;
      caps_r      <= 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) prev_keys_r[i] <= 8'h00;
    end else begin
      if (cfg_we) rep_delay_r <= cfg_wdata;
      if (accept) begin
        prev_mods_r <= prev_mods_nxt;
        rep_usage_r <= rep_usage_nxt;
        rep_count_r <= rep_count_nxt;
        caps_r      <= caps_nxt;
        if (changed) begin
          for (int i = 0; i < KEY_SLOTS; i++) prev_keys_r[i] <= keys[i];
        end
      end
    end
  end

  hbps2_merge #(.NEV(NEV)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .ev_valid  (ev_valid),
    .ev        (ev),
    .load_ok   (load_ok),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_ev    (out_ev),
    .out_last  (out_last)
  );

  assign out_tdata = {7'd0, out_ev.caps, out_ev.scancode};
  assign out_tuser = {out_ev.repeated, out_ev.released, out_ev.extended};
  assign out_tlast = out_last;

endmodule

[design/hbps2_lane.sv]
// ============================================================================
// hbps2_lane
// One key slot: checks whether its usage is absent from the other report and
// looks up the scancode it would emit.
// ============================================================================
module hbps2_lane
  import hbps2_pkg::*;
#(
  parameter int KEY_SLOTS = 6
) (
  input  logic [7:0] usage,
  input  logic [7:0] others [KEY_SLOTS],
  output lane_t      lane
);

  logic held;

  // Membership test against every slot of the other report
  always_comb begin
    held = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (others[j] == usage) held = 1'b1;
    end
  end

  assign lane.fire     = (usage >= USAGE_MIN) && !held;
  assign lane.scancode = usage_lookup(usage);
  assign lane.extended = usage_is_ext(usage);

endmodule

[design/hbps2_merge.sv]
// ============================================================================
// hbps2_merge
// Holds the events found by the lanes of one report and sends them out
// lowest position first via an output register, one per cycle unless stalled.
// ============================================================================
module hbps2_merge
  import hbps2_pkg::*;
#(
  parameter int NEV = 19
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic [NEV-1:0] ev_valid,
  input  event_t         ev [NEV],
  output logic           load_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output event_t         out_ev,
  output logic           out_last
);

  logic [NEV-1:0] pend_r, pend_nxt;
  event_t         ev_r [NEV];
  logic [NEV-1:0] sel;
  logic           pop, single;
  event_t         pick;
  logic           out_valid_r;
  event_t         out_ev_r;
  logic           out_last_r;

  // Lowest pending event, one-hot
  assign sel    = pend_r & (~pend_r + NEV'(1));
  assign single = (pend_r & ~sel) == '0;
  assign pop    = (pend_r != '0) && (!out_valid_r || out_ready);

  // A new report may enter once the bank empties this cycle
  assign load_ok = (pend_r == '0) || (single && pop);

  always_comb begin
    pick = '0;
    for (int i = 0; i < NEV; i++) begin
      if (sel[i]) pick = pick | ev_r[i];
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (pop) pend_nxt = pend_r & ~sel;
    if (load) pend_nxt = ev_valid;
  end

  // Pending bank
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
    if (load) ev_r <= ev;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (pop) begin
      out_ev_r   <= pick;
      out_last_r <= single;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ev    = out_ev_r;
  assign out_last  = out_last_r;

endmodule

[design/hbps2_checker.sv]
// ============================================================================
// hbps2_checker
// Port-level checks on the event stream of the translator.
// ============================================================================
module hbps2_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // No event straight after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("event valid after reset");

  // A stalled event holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled event changed");

  // No new report while more events of the current one are queued
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast && !out_tready |-> !in_tready)
    else $error("report taken mid-burst");

  // A repeat is a lone make event
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tlast && !out_tuser[1])
    else $error("malformed repeat event");

endmodule

bind hid_boot_report_to_ps2_events_core hbps2_checker u_hbps2_checker (.*);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boot keyboard report to PS/2 set-1 event translator: testbench
// Sends keyboard reports through the input stream and predicts the make,
// break and repeat events of each one from a local model of the key state.
// Each event out of the block is checked field by field against the oldest
// outstanding prediction. Directed reports cover modifiers, duplicates, low
// and unmapped usages, Caps Lock and the typematic repeat; random typing
// sequences follow under several repeat delays, with stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

  // Usages with special handling
  localparam logic [7:0] KEY_LOWEST   = 8'h04;
  localparam logic [7:0] KEY_CAPS     = 8'h39;
  localparam logic [7:0] KEY_NO_REPT  = 8'hE0;
  localparam int         CODE_ENTRIES = 102;
  localparam logic [7:0] DELAY_AFTER_RESET = 8'd12;

  // Modifier bits in event order: LCtrl, LShift, LAlt, RCtrl, RShift, RAlt
  localparam int         MOD_BIT  [6] = '{0, 1, 2, 4, 5, 6};
  localparam logic [7:0] MOD_CODE [6] = '{8'h1D, 8'h2A, 8'h38, 8'h1D, 8'h36, 8'h38};
  localparam logic       MOD_E0   [6] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

  // Set-1 scancode per usage, zero where the usage has none
  localparam logic [7:0] SET1_CODE [CODE_ENTRIES] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25,
    8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14, 8'h16, 8'h2F,
    8'h11, 8'h2D, 8'h15, 8'h2C,
    8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
    8'h1C, 8'h01, 8'h0E, 8'h0F, 8'h39, 8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h2B, 8'h2B,
    8'h27, 8'h28, 8'h29, 8'h33, 8'h34, 8'h35,
    8'h3A,
    8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h57,
    8'h58,
    8'h00, 8'h46, 8'h00,
    8'h52, 8'h47, 8'h49, 8'h53, 8'h4F, 8'h51,
    8'h4D, 8'h4B, 8'h50, 8'h48,
    8'h45, 8'h35, 8'h37, 8'h4A, 8'h4E, 8'h1C, 8'h4F, 8'h50, 8'h51, 8'h4B, 8'h4C,
    8'h4D, 8'h47, 8'h48, 8'h49, 8'h52, 8'h53,
    8'h56, 8'h00
  };

  // One report, laid out as it travels in in_tdata (modifiers lowest)
  typedef struct packed {
    logic [2:0]      valid;
    logic [5:0][7:0] key;
    logic [7:0]      mods;
  } report_t;

  typedef struct packed {
    logic [7:0] scancode;
    logic       extended;
    logic       released;
    logic       repeated;
    logic       caps_state;
    logic       last;
  } ps2_event_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  // Local copy of the key state and register
  logic [7:0]      repeat_delay = DELAY_AFTER_RESET;
  logic [7:0]      held_mods = '0;
  logic [5:0][7:0] held_keys = '0;
  logic [7:0]      repeat_key = '0;
  logic [7:0]      repeat_wait = '0;
  logic            caps_on = 1'b0;

  ps2_event_t pending_events[$];
  ps2_event_t seen_event;
  int         error_count = 0;
  int         burst_left = 0;

  // Random typing state
  report_t typing_now = '0;
  int      typing_held = 0;

  // Receiver stall pattern
  int rx_tick = 0;
  int rx_mode = 0;

  hid_boot_report_to_ps2_events_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model --

  function automatic logic [7:0] code_of(input logic [7:0] usage);
    return (usage < CODE_ENTRIES) ? SET1_CODE[usage] : 8'h00;
  endfunction

  function automatic logic needs_e0(input logic [7:0] usage);
    return (usage >= 8'h49 && usage <= 8'h52) || usage == 8'h54 || usage == 8'h58;
  endfunction

  function automatic logic held_in(input logic [7:0] usage, input logic [5:0][7:0] keys);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < 6; i++) if (keys[i] == usage) hit = 1'b1;
    return hit;
  endfunction

  function automatic void add_event(input logic [7:0] sc, input logic ext,
                                    input logic rel, input logic rep);
    ps2_event_t ev;
    ev = '{scancode: sc, extended: ext, released: rel, repeated: rep,
           caps_state: caps_on, last: 1'b0};
    pending_events.push_back(ev);
  endfunction

  // Events one report causes, updating the local key state
  function automatic void predict_ps2_events(input report_t r);
    logic [5:0][7:0] keys;
    logic [7:0]      u;
    logic [7:0]      sc;
    logic            was_on;
    logic            is_on;
    int              first;
    first = pending_events.size();
    for (int i = 0; i < 6; i++) keys[i] = (i < r.valid) ? r.key[i] : 8'h00;

    if (r.mods != held_mods || keys != held_keys) begin
      // modifier transitions
      for (int m = 0; m < 6; m++) begin
        was_on = held_mods[MOD_BIT[m]];
        is_on  = r.mods[MOD_BIT[m]];
        if (was_on != is_on) add_event(MOD_CODE[m], MOD_E0[m], ~is_on, 1'b0);
      end
      // keys that left the report
      for (int i = 0; i < 6; i++) begin
        u = held_keys[i];
        if (u >= KEY_LOWEST && !held_in(u, keys)) begin
          if (u == repeat_key) repeat_key = 8'h00;
          sc = code_of(u);
          if (sc != 8'h00) add_event(sc, needs_e0(u), 1'b1, 1'b0);
        end
      end
      // keys that entered it
      for (int i = 0; i < 6; i++) begin
        u = keys[i];
        if (u >= KEY_LOWEST && !held_in(u, held_keys)) begin
          if (u < KEY_NO_REPT && u != KEY_CAPS) begin
            repeat_key  = u;
            repeat_wait = repeat_delay;
          end
          if (u == KEY_CAPS) caps_on = ~caps_on;
          sc = code_of(u);
          if (sc != 8'h00) add_event(sc, needs_e0(u), 1'b0, 1'b0);
        end
      end
      held_mods = r.mods;
      held_keys = keys;
    end else if (repeat_key != 8'h00) begin
      // typematic countdown, then repeat
      if (repeat_wait > 0) begin
        repeat_wait = repeat_wait - 8'd1;
      end else begin
        sc = code_of(repeat_key);
        if (sc != 8'h00) add_event(sc, needs_e0(repeat_key), 1'b0, 1'b1);
      end
    end

    if (pending_events.size() > first) pending_events[pending_events.size()-1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------- checking --

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event transfer: scancode %h", out_tdata[7:0]);
        error_count++;
      end else begin
        seen_event = pending_events.pop_front();
        check_field("scancode",   seen_event.scancode,   out_tdata[7:0]);
        check_field("caps_state", seen_event.caps_state, out_tdata[8]);
        check_field("extended",   seen_event.extended,   out_tuser[0]);
        check_field("released",   seen_event.released,   out_tuser[1]);
        check_field("repeated",   seen_event.repeated,   out_tuser[2]);
        check_field("last",       seen_event.last,       out_tlast);
      end
    end
  end

  // Receiver: switches between randomly chosen stall patterns
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 40 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= (rx_tick % 3 == 0);
      end
      default: begin
        out_tready <= ($urandom_range(0, 7) != 0);
      end
    endcase
  end

  // ------------------------------------------------------------- stimulus --

  function automatic report_t mk(input logic [7:0] mods, input logic [2:0] valid,
                                 input logic [7:0] k0, input logic [7:0] k1,
                                 input logic [7:0] k2, input logic [7:0] k3,
                                 input logic [7:0] k4, input logic [7:0] k5);
    report_t r;
    r.mods  = mods;
    r.valid = valid;
    r.key   = {k5, k4, k3, k2, k1, k0};
    return r;
  endfunction

  // One report transfer; the sender runs in bursts with idle gaps between
  task automatic send_report(input report_t r);
    int gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, r};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ps2_events(r);
    burst_left--;
  endtask

  // Stop sending and wait for every predicted event plus the pipeline tail
  task automatic wait_idle();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_repeat_delay(input logic [7:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    repeat_delay = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_usage();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) return 8'($urandom_range(4, 8'h65));
    if (p < 78) return KEY_CAPS;
    if (p < 86) return 8'($urandom_range(8'hE0, 8'hFF));
    if (p < 92) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(8'h66, 8'hDF));
  endfunction

  // Next report of a typing sequence: mostly plausible edits, some noise
  task automatic typing_step(output report_t r);
    int p;
    int idx;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      // unchanged report, drives the repeat
    end else if (p < 40) begin
      if (typing_held < 6) begin
        typing_now.key[typing_held] = rand_usage();
        typing_held++;
      end else begin
        typing_now.key[$urandom_range(0, 5)] = rand_usage();
      end
    end else if (p < 60) begin
      if (typing_held > 0) begin
        idx = $urandom_range(0, typing_held - 1);
        for (int j = idx; j < typing_held - 1; j++) typing_now.key[j] = typing_now.key[j+1];
        typing_now.key[typing_held-1] = 8'($urandom);
        typing_held--;
      end
    end else if (p < 75) begin
      typing_now.mods[$urandom_range(0, 7)] ^= 1'b1;
    end else if (p < 87) begin
      if (typing_held > 0) typing_now.key[$urandom_range(0, typing_held - 1)] = rand_usage();
    end else begin
      typing_now.mods = 8'($urandom);
      typing_now.key  = 48'({$urandom, $urandom});
      typing_now.valid = 3'($urandom_range(0, 7));
      typing_held = (typing_now.valid > 6) ? 6 : typing_now.valid;
    end
    typing_now.valid = 3'(typing_held);
    r = typing_now;
    // occasionally a valid count that disagrees with the held keys
    if ($urandom_range(0, 99) < 8) r.valid = 3'($urandom_range(0, 7));
  endtask

  // ---------------------------------------------------------------- tests --

  task automatic test_directed_reports();
    // all modifier bits on, then only the GUI bits, then nothing
    send_report(mk(8'hFF, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h88, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // low usages only
    send_report(mk(8'h00, 3'd3, 8'h01, 8'h02, 8'h03, 8'h00, 8'h00, 8'h00));
    // one valid slot, rubbish beyond it
    send_report(mk(8'h00, 3'd1, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // over-range count, duplicate, no-repeat usage, Caps Lock, keypad slash
    send_report(mk(8'h00, 3'd7, 8'h04, 8'h1D, 8'h04, 8'hFF, 8'h39, 8'h54));
    // release everything; the duplicate breaks twice
    send_report(mk(8'h00, 3'd0, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
    send_report(mk(8'h00, 3'd1, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // extended keys and unmapped usages
    send_report(mk(8'h00, 3'd6, 8'h4F, 8'h58, 8'h46, 8'h48, 8'h65, 8'h80));
    send_report(mk(8'h00, 3'd6, 8'h4F, 8'h58, 8'h46, 8'h48, 8'h65, 8'h80));
    send_report(mk(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h7F, 3'd3, 8'h29, 8'hE3, 8'hE0, 8'h00, 8'h00, 8'h00));
    send_report(mk(8'h80, 3'd5, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00));
    // keys shift down a slot: only the departed one breaks
    send_report(mk(8'h00, 3'd4, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00, 8'h00));
    send_report(mk(8'h00, 3'd6, 8'h49, 8'h52, 8'h64, 8'h2C, 8'h28, 8'h2A));
    send_report(mk(8'h00, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  task automatic hold_report(input report_t r, input int count);
    for (int i = 0; i < count; i++) send_report(r);
  endtask

  task automatic test_typematic();
    // no delay: repeats start with the first unchanged report
    set_repeat_delay(8'd0);
    hold_report(mk(8'h00, 3'd1, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 4);
    hold_report(mk(8'h00, 3'd2, 8'h50, 8'h1A, 8'h00, 8'h00, 8'h00, 8'h00), 3);
    // releasing the repeating key stops the repeat
    hold_report(mk(8'h00, 3'd1, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 3);
    // Caps Lock does not repeat
    hold_report(mk(8'h00, 3'd2, 8'h50, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00), 3);
    // unmapped key repeats silently
    hold_report(mk(8'h00, 3'd1, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 3);
    // longest delay: no repeat within a few reports
    set_repeat_delay(8'd255);
    hold_report(mk(8'h00, 3'd1, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 5);
    set_repeat_delay(8'd3);
    hold_report(mk(8'h00, 3'd1, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 7);
  endtask

  task automatic test_random_typing();
    report_t r;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_repeat_delay(8'd0);
        1: set_repeat_delay(8'($urandom_range(1, 5)));
        2: set_repeat_delay(DELAY_AFTER_RESET);
        default: set_repeat_delay(8'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < 75; i++) begin
        typing_step(r);
        send_report(r);
      end
    end
  endtask

  // ----------------------------------------------------------------- main --

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_reports();
    test_typematic();
    test_random_typing();
    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
